// ----- rtl/rfhdb_pkg.sv -----
// Shared types and constants for the RTU frame half-duplex buffer.
// No dependencies; used by every module in rtl/.
package rfhdb_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int POS_W     = 9;
  localparam int TMR_W     = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    OP_RX_BYTE = 3'd0,
    OP_TICK    = 3'd1,
    OP_TX_SLOT = 3'd2,
    OP_TX_DONE = 3'd3,
    OP_BUF_RD  = 3'd4,
    OP_BUF_WR  = 3'd5,
    OP_SEND    = 3'd6,
    OP_NOP     = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_FRAME  = 3'd1,
    EV_TXBYTE = 3'd2,
    EV_READ   = 3'd3,
    EV_TXDONE = 3'd4
  } event_t;

  typedef enum logic [3:0] {
    MODE_RX    = 4'b0001,
    MODE_WAIT  = 4'b0010,
    MODE_TX    = 4'b0100,
    MODE_DRAIN = 4'b1000
  } mode_t;

  localparam logic [0:0] REG_SILENCE_RELOAD = 1'b0;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // per-word result, registered alongside the buffer read
  typedef struct packed {
    event_t           ev;
    logic [POS_W-1:0] flen;
    logic             de;
    logic             listen;
    logic             use_mem;
  } res_t;

  typedef struct packed {
    event_t           ev;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] flen;
    logic             de;
    logic             listen;
  } out_word_t;

endpackage

// ----- rtl/rtu_frame_half_duplex_buffer_core.sv -----
// Top level of the RTU frame half-duplex buffer.
// Depends on rfhdb_pkg, rfhdb_ram, rfhdb_ctrl and rfhdb_skid.
//
// Half-duplex frame buffer for a serial slave. Every input word (rx byte,
// timer tick, tx slot free, tx done, buffer read/write, send) yields exactly
// one output word. Words are taken one per clock while the output side is not
// stalled; each result passes through the registered 256x8 buffer read and
// then the output register. Back-pressure is absorbed by a two-entry output
// register, so the input side keeps going while a result waits. The frame
// buffer is not cleared by reset; reading a never-written entry returns an
// unspecified byte. silence_reload is at APB byte address 0.
module rtu_frame_half_duplex_buffer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] rx_data, [8] rx_error, [16:9] buf_addr, [24:17] write_data,
  // [33:25] send_length, rest zero
  input  logic [rfhdb_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [2:0] opcode
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] data_byte, [16:8] frame_length, [17] driver_enable, [18] listening
  output logic [rfhdb_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [2:0] event_res
  output logic [2:0]                          m_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [rfhdb_pkg::TMR_W-1:0] silence_reload;
  logic                        accept;
  logic                        s1_valid;
  logic                        skid_ready;
  logic                        push;
  rfhdb_pkg::mem_req_t         mem_req;
  rfhdb_pkg::res_t             res;
  rfhdb_pkg::out_word_t        s1_word;
  rfhdb_pkg::out_word_t        out_word;
  logic [7:0]                  rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rfhdb_pkg::REG_SILENCE_RELOAD) ?
                  {16'b0, silence_reload} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_reload <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rfhdb_pkg::REG_SILENCE_RELOAD) begin
      silence_reload <= pwdata[rfhdb_pkg::TMR_W-1:0];
    end
  end

  assign push     = s1_valid && skid_ready;
  assign s_tready = !s1_valid || skid_ready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  rfhdb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (rfhdb_pkg::opcode_t'(s_tuser)),
    .rx_data        (s_tdata[7:0]),
    .rx_error       (s_tdata[8]),
    .buf_addr       (s_tdata[16:9]),
    .write_data     (s_tdata[24:17]),
    .send_length    (s_tdata[33:25]),
    .silence_reload (silence_reload),
    .mem_req        (mem_req),
    .res            (res)
  );

  rfhdb_ram u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_comb begin
    s1_word.ev        = res.ev;
    s1_word.data_byte = res.use_mem ? rdata : 8'd0;
    s1_word.flen      = res.flen;
    s1_word.de        = res.de;
    s1_word.listen    = res.listen;
  end

  rfhdb_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (skid_ready),
    .in_word   (s1_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tuser = out_word.ev;
  assign m_tdata = {5'b0, out_word.listen, out_word.de, out_word.flen, out_word.data_byte};

endmodule

// ----- rtl/rfhdb_ram.sv -----
// Frame buffer storage: one write port, one read port, registered read data.
// Depends on rfhdb_pkg for depth and address width.
module rfhdb_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [rfhdb_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [rfhdb_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                   rdata
);

  logic [7:0] mem [rfhdb_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rfhdb_ctrl.sv -----
// Link control: receive/transmit mode, positions, silence timer, buffer
// access requests and the result stage. Depends on rfhdb_pkg.
module rfhdb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  rfhdb_pkg::opcode_t          opcode,
  input  logic [7:0]                  rx_data,
  input  logic                        rx_error,
  input  logic [7:0]                  buf_addr,
  input  logic [7:0]                  write_data,
  input  logic [rfhdb_pkg::POS_W-1:0] send_length,
  input  logic [rfhdb_pkg::TMR_W-1:0] silence_reload,
  output rfhdb_pkg::mem_req_t         mem_req,
  output rfhdb_pkg::res_t             res
);

  localparam logic [rfhdb_pkg::POS_W-1:0] DEPTH_POS = rfhdb_pkg::POS_W'(rfhdb_pkg::BUF_DEPTH);

  rfhdb_pkg::mode_t             mode, mode_next;
  logic [rfhdb_pkg::POS_W-1:0]  position, position_next;
  logic [rfhdb_pkg::POS_W-1:0]  remaining, remaining_next;
  logic [rfhdb_pkg::TMR_W-1:0]  silence_count, silence_count_next;
  logic                         timer_running, timer_running_next;
  logic                         direction_out, direction_out_next;
  rfhdb_pkg::res_t              res_next;
  logic [rfhdb_pkg::POS_W-1:0]  slen_sat;
  logic [rfhdb_pkg::POS_W-1:0]  rem_dec;
  logic                         addr_ok;

  assign slen_sat = (send_length > DEPTH_POS) ? DEPTH_POS : send_length;
  assign addr_ok  = ({1'b0, buf_addr} < DEPTH_POS);

  always_comb begin
    mode_next          = mode;
    position_next      = position;
    remaining_next     = remaining;
    silence_count_next = silence_count;
    timer_running_next = timer_running;
    direction_out_next = direction_out;
    res_next.ev        = rfhdb_pkg::EV_NONE;
    res_next.flen      = '0;
    res_next.use_mem   = 1'b0;
    mem_req.we         = 1'b0;
    mem_req.waddr      = position[rfhdb_pkg::ADDR_W-1:0];
    mem_req.wdata      = rx_data;
    mem_req.raddr      = position[rfhdb_pkg::ADDR_W-1:0];
    rem_dec            = remaining - 1'b1;

    unique case (opcode)
      rfhdb_pkg::OP_RX_BYTE: begin
        if (mode == rfhdb_pkg::MODE_RX) begin
          timer_running_next = 1'b0;
          if (rx_error || position >= DEPTH_POS) begin
            position_next = '0;
          end else begin
            mem_req.we         = 1'b1;
            position_next      = position + 1'b1;
            silence_count_next = silence_reload;
            timer_running_next = 1'b1;
          end
        end
      end
      rfhdb_pkg::OP_TICK: begin
        if (timer_running) begin
          silence_count_next = silence_count + 1'b1;
          if (silence_count == '1) begin
            timer_running_next = 1'b0;
            mode_next          = rfhdb_pkg::MODE_WAIT;
            res_next.flen      = position;
            position_next      = '0;
            res_next.ev        = rfhdb_pkg::EV_FRAME;
          end
        end
      end
      rfhdb_pkg::OP_TX_SLOT: begin
        if (mode == rfhdb_pkg::MODE_TX && remaining != '0) begin
          res_next.use_mem = 1'b1;
          res_next.ev      = rfhdb_pkg::EV_TXBYTE;
          position_next    = position + 1'b1;
          remaining_next   = rem_dec;
          mode_next        = (rem_dec == '0) ? rfhdb_pkg::MODE_DRAIN : rfhdb_pkg::MODE_TX;
        end
      end
      rfhdb_pkg::OP_TX_DONE: begin
        if (mode == rfhdb_pkg::MODE_DRAIN) begin
          direction_out_next = 1'b0;
          position_next      = '0;
          remaining_next     = '0;
          mode_next          = rfhdb_pkg::MODE_RX;
          res_next.ev        = rfhdb_pkg::EV_TXDONE;
        end
      end
      rfhdb_pkg::OP_BUF_RD: begin
        mem_req.raddr    = buf_addr[rfhdb_pkg::ADDR_W-1:0];
        res_next.use_mem = addr_ok;
        res_next.ev      = rfhdb_pkg::EV_READ;
      end
      rfhdb_pkg::OP_BUF_WR: begin
        mem_req.we    = addr_ok;
        mem_req.waddr = buf_addr[rfhdb_pkg::ADDR_W-1:0];
        mem_req.wdata = write_data;
      end
      rfhdb_pkg::OP_SEND: begin
        if (mode == rfhdb_pkg::MODE_WAIT) begin
          position_next = '0;
          if (slen_sat == '0) begin
            mode_next = rfhdb_pkg::MODE_RX;
          end else begin
            // first byte goes out with the send itself, from entry 0
            direction_out_next = 1'b1;
            mem_req.raddr      = '0;
            res_next.use_mem   = 1'b1;
            res_next.ev        = rfhdb_pkg::EV_TXBYTE;
            position_next      = rfhdb_pkg::POS_W'(1);
            remaining_next     = slen_sat - 1'b1;
            mode_next          = (slen_sat == rfhdb_pkg::POS_W'(1)) ?
                                 rfhdb_pkg::MODE_DRAIN : rfhdb_pkg::MODE_TX;
          end
        end
      end
      default: begin
      end
    endcase

    res_next.de     = direction_out_next;
    res_next.listen = (mode_next == rfhdb_pkg::MODE_RX);
    mem_req.we      = mem_req.we & accept;
    mem_req.re      = accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= rfhdb_pkg::MODE_RX;
      position      <= '0;
      remaining     <= '0;
      silence_count <= '0;
      timer_running <= 1'b0;
      direction_out <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      position      <= position_next;
      remaining     <= remaining_next;
      silence_count <= silence_count_next;
      timer_running <= timer_running_next;
      direction_out <= direction_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/rfhdb_skid.sv -----
// Two-entry output register decoupling the result stage from the master side.
// Depends on rfhdb_pkg for the output word type.
module rfhdb_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rfhdb_pkg::out_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rfhdb_pkg::out_word_t out_word
);

  logic                 spare_valid;
  rfhdb_pkg::out_word_t spare_word;
  logic                 push;

  assign in_ready = !spare_valid;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid   <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_word <= spare_valid ? spare_word : in_word;
    end
    if (push && out_valid && !out_ready) begin
      spare_word <= in_word;
    end
  end

endmodule

// ----- verif/rtu_frame_half_duplex_buffer_core_test.sv -----
// Self-checking test for rtu_frame_half_duplex_buffer_core: stream words in, one result word out,
// checked against a behavioral predictor of the frame buffer, timer and link mode.
// Depends on rfhdb_pkg and the RTL under rtl/.
module rtu_frame_half_duplex_buffer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfhdb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    opcode_t    op;
    logic [7:0] rx_byte;
    logic       rx_err;
    logic [7:0] addr;
    logic [7:0] wr_byte;
    logic [8:0] len;
  } cmd_word_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [2:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0]             m_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // predicted block state
  logic [7:0]  mirror_buf [BUF_DEPTH];
  logic [8:0]  pr_pos;
  logic [8:0]  pr_left;
  logic [15:0] pr_silence;
  logic        pr_timer_on;
  mode_t       pr_mode;
  logic        pr_drive;
  logic [15:0] pr_reload;

  out_word_t due_words [$];
  out_word_t want_word;
  int        mismatches = 0;
  int        word_count = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        noise_pct = 0;

  rtu_frame_half_duplex_buffer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // result word check, oldest expectation first
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_words.size() == 0) begin
        flag_mismatch("word with nothing due, event", 16'(m_tuser), 16'd0);
      end else begin
        want_word = due_words.pop_front();
        if (m_tuser != want_word.ev)
          flag_mismatch("event", 16'(m_tuser), 16'(want_word.ev));
        if (m_tdata[7:0] != want_word.data_byte)
          flag_mismatch("data_byte", 16'(m_tdata[7:0]), 16'(want_word.data_byte));
        if (m_tdata[16:8] != want_word.flen)
          flag_mismatch("frame_length", 16'(m_tdata[16:8]), 16'(want_word.flen));
        if (m_tdata[17] != want_word.de)
          flag_mismatch("driver_enable", 16'(m_tdata[17]), 16'(want_word.de));
        if (m_tdata[18] != want_word.listen)
          flag_mismatch("listening", 16'(m_tdata[18]), 16'(want_word.listen));
      end
    end
  end

  function automatic logic [7:0] take_tx_byte();
    logic [7:0] b;
    b = (pr_pos < BUF_DEPTH) ? mirror_buf[pr_pos[7:0]] : 8'h00;
    pr_pos  = pr_pos + 9'd1;
    pr_left = pr_left - 9'd1;
    pr_mode = (pr_left == 9'd0) ? MODE_DRAIN : MODE_TX;
    return b;
  endfunction

  function automatic out_word_t advance_link(cmd_word_t c);
    out_word_t  r;
    logic [8:0] n;
    r.ev        = EV_NONE;
    r.data_byte = 8'h00;
    r.flen      = 9'd0;
    case (c.op)
      OP_RX_BYTE: begin
        if (pr_mode == MODE_RX) begin
          pr_timer_on = 1'b0;
          if (c.rx_err || pr_pos >= BUF_DEPTH) begin
            pr_pos = 9'd0;
          end else begin
            mirror_buf[pr_pos[7:0]] = c.rx_byte;
            pr_pos      = pr_pos + 9'd1;
            pr_silence  = pr_reload;
            pr_timer_on = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (pr_timer_on) begin
          pr_silence = pr_silence + 16'd1;
          if (pr_silence == 16'd0) begin
            pr_timer_on = 1'b0;
            pr_mode     = MODE_WAIT;
            r.ev        = EV_FRAME;
            r.flen      = pr_pos;
            pr_pos      = 9'd0;
          end
        end
      end
      OP_TX_SLOT: begin
        if (pr_mode == MODE_TX && pr_left != 9'd0) begin
          r.data_byte = take_tx_byte();
          r.ev        = EV_TXBYTE;
        end
      end
      OP_TX_DONE: begin
        if (pr_mode == MODE_DRAIN) begin
          pr_drive = 1'b0;
          pr_pos   = 9'd0;
          pr_left  = 9'd0;
          pr_mode  = MODE_RX;
          r.ev     = EV_TXDONE;
        end
      end
      OP_BUF_RD: begin
        r.data_byte = mirror_buf[c.addr];
        r.ev        = EV_READ;
      end
      OP_BUF_WR: mirror_buf[c.addr] = c.wr_byte;
      OP_SEND: begin
        if (pr_mode == MODE_WAIT) begin
          n      = (c.len > BUF_DEPTH) ? 9'(BUF_DEPTH) : c.len;
          pr_pos = 9'd0;
          if (n == 9'd0) begin
            pr_mode = MODE_RX;
          end else begin
            pr_left     = n;
            pr_drive    = 1'b1;
            r.data_byte = take_tx_byte();
            r.ev        = EV_TXBYTE;
          end
        end
      end
      default: ;
    endcase
    r.de     = pr_drive;
    r.listen = (pr_mode == MODE_RX);
    return r;
  endfunction

  function automatic cmd_word_t any_word();
    cmd_word_t c;
    c.op      = opcode_t'($urandom_range(7));
    c.rx_byte = 8'($urandom_range(255));
    c.rx_err  = 1'($urandom_range(1));
    c.addr    = 8'($urandom_range(255));
    c.wr_byte = 8'($urandom_range(255));
    c.len     = 9'($urandom_range(511));
    return c;
  endfunction

  task automatic send_word(cmd_word_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {6'b0, c.len, c.wr_byte, c.addr, c.rx_err, c.rx_byte};
    do @(posedge clk); while (!s_tready);
    due_words.push_back(advance_link(c));
    word_count++;
  endtask

  task automatic send_cmd(opcode_t op, logic [7:0] rxb, logic err, logic [7:0] addr,
                          logic [7:0] wd, logic [8:0] len);
    cmd_word_t c;
    c.op      = op;
    c.rx_byte = rxb;
    c.rx_err  = err;
    c.addr    = addr;
    c.wr_byte = wd;
    c.len     = len;
    send_word(c);
  endtask

  // random stray word ahead of the intended one, at noise_pct
  task automatic spaced_send(cmd_word_t c);
    if ($urandom_range(99) < noise_pct) send_word(any_word());
    send_word(c);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reload(logic [15:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SILENCE_RELOAD, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pr_reload = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // fills the whole buffer by reception, so every entry is defined from here on
  task automatic test_full_buffer();
    cmd_word_t c;
    set_reload(16'hFFFF);
    repeat (257) begin
      c = any_word();
      c.op = OP_RX_BYTE;
      c.rx_err = 1'b0;
      send_word(c);
    end
    send_cmd(OP_TICK, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    repeat (256) begin
      c = any_word();
      c.op = OP_RX_BYTE;
      c.rx_err = 1'b0;
      send_word(c);
    end
    send_cmd(OP_TICK, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_BUF_RD, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_BUF_RD, 8'h00, 1'b0, 8'hFF, 8'h00, 9'd0);
    send_cmd(OP_SEND, 8'h00, 1'b0, 8'h00, 8'h00, 9'h1FF);
    repeat (256) send_cmd(OP_TX_SLOT, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
  endtask

  task automatic test_special_cases();
    set_reload(16'hFFFE);
    send_cmd(OP_RX_BYTE, 8'h00, 1'b1, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TICK,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);  // timer stopped
    send_cmd(OP_RX_BYTE, 8'hFF, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_RX_BYTE, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TICK,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TICK,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_RX_BYTE, 8'h5A, 1'b0, 8'h00, 8'h00, 9'd0);  // receiver off
    send_cmd(OP_TX_SLOT, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_BUF_WR,  8'h00, 1'b0, 8'hFF, 8'hFF, 9'd0);
    send_cmd(OP_BUF_RD,  8'h00, 1'b0, 8'hFF, 8'h00, 9'd0);
    send_cmd(OP_BUF_RD,  8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_SEND,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);  // resume listening
    send_cmd(OP_SEND,    8'h00, 1'b0, 8'h00, 8'h00, 9'd3);  // not awaiting
    send_cmd(OP_RX_BYTE, 8'hA5, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TICK,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TICK,    8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_SEND,    8'h00, 1'b0, 8'h00, 8'h00, 9'd1);
    send_cmd(OP_TX_SLOT, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);  // draining
    send_cmd(OP_SEND,    8'h00, 1'b0, 8'h00, 8'h00, 9'd5);
    send_cmd(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_NOP,     8'hFF, 1'b1, 8'hFF, 8'hFF, 9'h1FF);
  endtask

  // one request/response exchange with random content
  task automatic run_session();
    cmd_word_t c;
    int        n;
    int        pick;
    n = $urandom_range(10);
    repeat (n) begin
      c = any_word();
      c.op = OP_RX_BYTE;
      c.rx_err = ($urandom_range(9) == 0);
      spaced_send(c);
    end
    while (pr_mode == MODE_RX) begin
      c = any_word();
      c.op = pr_timer_on ? OP_TICK : OP_RX_BYTE;
      c.rx_err = 1'b0;
      spaced_send(c);
    end
    n = $urandom_range(3);
    repeat (n) begin
      c = any_word();
      c.op = $urandom_range(1) ? OP_BUF_RD : OP_BUF_WR;
      spaced_send(c);
    end
    while (pr_mode == MODE_WAIT) begin
      c = any_word();
      c.op = OP_SEND;
      pick = $urandom_range(99);
      if (pick < 10) c.len = 9'd0;
      else if (pick < 15) c.len = 9'($urandom_range(200, 511));
      else c.len = 9'($urandom_range(1, 16));
      spaced_send(c);
    end
    while (pr_mode == MODE_TX || pr_mode == MODE_DRAIN) begin
      c = any_word();
      c.op = (pr_mode == MODE_DRAIN && $urandom_range(3) != 0) ? OP_TX_DONE : OP_TX_SLOT;
      spaced_send(c);
    end
  endtask

  task automatic test_random_phases();
    int src_pct [4]  = '{0, 50, 0, 28};
    int sink_pct [4] = '{0, 0, 50, 28};
    int start;
    for (int p = 0; p < 4; p++) begin
      set_reload((p == 0) ? 16'hFFFF : 16'(65536 - $urandom_range(2, 16)));
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      noise_pct      = 15;
      start = word_count;
      while (word_count - start < 125) run_session();
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_NOP;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    for (int i = 0; i < BUF_DEPTH; i++) mirror_buf[i] = 8'h00;
    pr_pos      = 9'd0;
    pr_left     = 9'd0;
    pr_silence  = 16'd0;
    pr_timer_on = 1'b0;
    pr_mode     = MODE_RX;
    pr_drive    = 1'b0;
    pr_reload   = 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_full_buffer();
    test_special_cases();
    test_random_phases();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
